[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");

`endif

[rtl/gtc_pkg.sv]
package gtc_pkg;

   localparam int VALUE_MAX_DEF  = 2048;
   localparam int SUFFIX_MAX_DEF = 16;
   localparam int WORD_BITS_DEF  = 64;
   localparam int MAX_RESULTS    = 34;

   localparam int VALUE_W     = 16;
   localparam int OUT_WORD_W  = 64;
   localparam int BIT_COUNT_W = 7;
   localparam int K_W         = 5;
   localparam int CB_W        = 5;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 5;

   // floor(x / 3) = (x * DIV3_RECIP) >> DIV3_SHIFT, exact for x < 2^17
   localparam logic [VALUE_W-1:0] DIV3_RECIP = 16'd43691;
   localparam int                 DIV3_SHIFT = 17;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_USE_CODEBOOK    = 4'd0,
      CSR_CODEBOOK_NUMBER = 4'd1,
      CSR_EXPLICIT_K      = 4'd2,
      CSR_EXPLICIT_CLASS  = 4'd3
   } gtc_csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SPLIT,
      ST_RUN,
      ST_TAIL,
      ST_FLUSH,
      ST_ERROR
   } gtc_state_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } gtc_req_type;

   typedef struct packed {
      logic [OUT_WORD_W-1:0]  out_word;
      logic [BIT_COUNT_W-1:0] bit_count;
      logic                   end_of_run;
      logic                   range_error;
   } gtc_rsp_type;

   typedef struct packed {
      logic word_done;
      logic seg_done;
   } gtc_pack_stat_type;

endpackage

[rtl/gtc_pack_unit.sv]
module gtc_pack_unit #(
   parameter int WordBits = gtc_pkg::WORD_BITS_DEF,
   parameter int TailW    = gtc_pkg::SUFFIX_MAX_DEF + 3
) (
   input  logic [WordBits-1:0]                 pack_reg,
   input  logic [$clog2(WordBits+1)-1:0]       pack_fill,
   input  logic [gtc_pkg::VALUE_W-1:0]         left,
   input  logic                                tail_mode,
   input  logic [TailW-1:0]                    tail,
   output logic [WordBits-1:0]                 word,
   output logic [$clog2(WordBits+1)-1:0]       new_fill,
   output logic [gtc_pkg::VALUE_W-1:0]         left_next,
   output gtc_pkg::gtc_pack_stat_type          stat
);
   import gtc_pkg::*;

   localparam int FillW = $clog2(WordBits + 1);

   logic [FillW-1:0]          space;
   logic [FillW-1:0]          n;
   logic [WordBits-1:0]       nmask;
   logic [VALUE_W-1:0]        shamt;
   logic [WordBits+TailW-1:0] tail_wide;
   logic [WordBits-1:0]       chunk;

   // take as many bits as fit in the open word
   assign space = FillW'(WordBits) - pack_fill;
   assign n     = (left < VALUE_W'(space)) ? FillW'(left) : space;
   assign nmask = ~({WordBits{1'b1}} << n);

   // next n bits: the tail's, MSB first, or n ones for the unary run
   assign shamt     = left - VALUE_W'(n);
   assign tail_wide = {{WordBits{1'b0}}, tail} >> shamt;
   assign chunk     = tail_mode ? (tail_wide[WordBits-1:0] & nmask) : nmask;

   assign word           = (pack_reg << n) | chunk;
   assign new_fill       = pack_fill + n;
   assign left_next      = left - VALUE_W'(n);
   assign stat.word_done = (new_fill == FillW'(WordBits));
   assign stat.seg_done  = (left == VALUE_W'(n));

endmodule

[rtl/golomb_two_class_bit_encoder_top.sv]
// Channel  Dir  Handshake                    Beat payload
// req      in   req_valid / req_stall        value, last
// rsp      out  rsp_valid / rsp_stall        out_word, bit_count, end_of_run, range_error
// csr      in   csr_valid / csr_ready        csr_index, csr_data
//
// Each in-range item steps through accept, divide and split, then one packer
// pass per word the unary run touches and one or two passes for the tail,
// plus a flush when a last item leaves bits pending. The shared packer adds
// at most one word-sized slice per cycle. A completed word waits in the output
// register, and while it waits the packer holds any further word it completes.
// Reset is synchronous and active high; it clears the packer and loads the
// register defaults. csr_ready is always high; write only while idle.
`include "assert_macros.svh"

module golomb_two_class_bit_encoder_top #(
   parameter int ValueMax  = gtc_pkg::VALUE_MAX_DEF,
   parameter int SuffixMax = gtc_pkg::SUFFIX_MAX_DEF,
   parameter int WordBits  = gtc_pkg::WORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  gtc_pkg::gtc_req_type                req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output gtc_pkg::gtc_rsp_type                rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gtc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gtc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import gtc_pkg::*;

   localparam int FillW    = $clog2(WordBits + 1);
   localparam int TailW    = SuffixMax + 3;
   localparam int TailLenW = $clog2(TailW + 1);
   localparam int ResW     = $clog2(MAX_RESULTS + 1);

   // configuration registers
   logic            use_codebook_ff;
   logic [CB_W-1:0] codebook_number_ff;
   logic [K_W-1:0]  explicit_k_ff;
   logic            explicit_class_ff;

   // sequencer and per-item working registers
   gtc_state_type       state_ff, state_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic                last_ff, last_in;
   logic [K_W-1:0]      k_ff, k_in;
   logic                cls_ff, cls_in;
   logic [VALUE_W-1:0]  t_ff, t_in;
   logic [VALUE_W-1:0]  q_ff, q_in;
   logic [VALUE_W-1:0]  left_ff, left_in;
   logic [TailW-1:0]    tail_ff, tail_in;
   logic [TailLenW-1:0] tail_len_ff, tail_len_in;
   logic [ResW-1:0]     res_cnt_ff, res_cnt_in;

   // packer state
   logic [WordBits-1:0] pack_reg_ff, pack_reg_in;
   logic [FillW-1:0]    pack_fill_ff, pack_fill_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   gtc_rsp_type rsp_ff, rsp_in;

   // combinational helpers
   logic [K_W-1:0]         k_raw;
   logic [K_W-1:0]         k_sat;
   logic                   accept;
   logic                   out_free;
   logic                   drop;
   logic [VALUE_W-1:0]     vm1;
   logic [VALUE_W-1:0]     t_shift;
   logic [2*VALUE_W-1:0]   prod;
   logic [VALUE_W-1:0]     j_full;
   logic [1:0]             head_val;
   logic [1:0]             head_len;
   logic [TailW-1:0]       low_bits;
   logic [TailW-1:0]       tail_new;
   logic [TailLenW-1:0]    tail_len_new;
   logic [WordBits-1:0]    flush_word;
   logic [WordBits-1:0]    pk_word;
   logic [FillW-1:0]       pk_fill;
   logic [VALUE_W-1:0]     pk_left;
   gtc_pack_stat_type      pk_stat;
   logic                   advance;
   logic [VALUE_W-1:0]     bits_after;
   logic                   word_final;

   assign csr_ready   = 1'b1;
   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign drop        = (res_cnt_ff == ResW'(MAX_RESULTS));

   // suffix size from the codebook or the explicit register, saturated
   always_comb begin
      if (use_codebook_ff) begin
         if (codebook_number_ff[0]) begin
            k_raw = K_W'({1'b0, codebook_number_ff[CB_W-1:1]});
         end else begin
            k_raw = K_W'({1'b0, codebook_number_ff[CB_W-1:1]}) + K_W'(1);
         end
      end else begin
         k_raw = explicit_k_ff;
      end
      k_sat = (k_raw > K_W'(SuffixMax)) ? K_W'(SuffixMax) : k_raw;
   end

   // quotient: (value-1) >> k, divided by three for class 1
   assign vm1     = value_ff - VALUE_W'(1);
   assign t_shift = vm1 >> k_ff;
   assign prod    = {{VALUE_W{1'b0}}, t_shift} * {{VALUE_W{1'b0}}, DIV3_RECIP};

   // middle code from the remainder of the divide by three
   assign j_full = t_ff - q_ff - (q_ff << 1);

   always_comb begin
      if (!cls_ff) begin
         head_val = 2'd0;
         head_len = 2'd1;
      end else begin
         case (j_full[1:0])
            2'd0: begin
               head_val = 2'd0;
               head_len = 2'd2;
            end
            2'd1: begin
               head_val = 2'd2;
               head_len = 2'd3;
            end
            default: begin
               head_val = 2'd3;
               head_len = 2'd3;
            end
         endcase
      end
   end

   assign low_bits     = TailW'(vm1) & ~({TailW{1'b1}} << k_ff);
   assign tail_new     = (TailW'(head_val) << k_ff) | low_bits;
   assign tail_len_new = TailLenW'(head_len) + TailLenW'(k_ff);
   assign flush_word   = pack_reg_ff << (FillW'(WordBits) - pack_fill_ff);

   gtc_pack_unit #(
      .WordBits (WordBits),
      .TailW    (TailW)
   ) u_pack (
      .pack_reg  (pack_reg_ff),
      .pack_fill (pack_fill_ff),
      .left      (left_ff),
      .tail_mode (state_ff == ST_TAIL),
      .tail      (tail_ff),
      .word      (pk_word),
      .new_fill  (pk_fill),
      .left_next (pk_left),
      .stat      (pk_stat)
   );

   // a finished word needs room downstream unless it is past the result limit
   assign advance = !pk_stat.word_done || out_free || drop;

   // bits of this item still to pack once the current word closes; the word is
   // the item's last beat when they neither fill another word nor get flushed
   assign bits_after = (state_ff == ST_RUN) ? (pk_left + VALUE_W'(tail_len_ff)) : pk_left;
   assign word_final = (bits_after < VALUE_W'(WordBits)) &&
                       !(last_ff && (bits_after != '0));

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      k_in         = k_ff;
      cls_in       = cls_ff;
      t_in         = t_ff;
      q_in         = q_ff;
      left_in      = left_ff;
      tail_in      = tail_ff;
      tail_len_in  = tail_len_ff;
      res_cnt_in   = res_cnt_ff;
      pack_reg_in  = pack_reg_ff;
      pack_fill_in = pack_fill_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in   = req_payload.value;
               last_in    = req_payload.last;
               k_in       = k_sat;
               cls_in     = use_codebook_ff ? codebook_number_ff[0] : explicit_class_ff;
               res_cnt_in = '0;
               if (req_payload.value == '0 ||
                   req_payload.value > VALUE_W'(ValueMax)) begin
                  state_in = ST_ERROR;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end

         ST_DIVIDE: begin
            t_in     = t_shift;
            q_in     = cls_ff ? VALUE_W'(prod >> DIV3_SHIFT) : t_shift;
            state_in = ST_SPLIT;
         end

         ST_SPLIT: begin
            tail_in     = tail_new;
            tail_len_in = tail_len_new;
            if (q_ff != '0) begin
               left_in  = q_ff;
               state_in = ST_RUN;
            end else begin
               left_in  = VALUE_W'(tail_len_new);
               state_in = ST_TAIL;
            end
         end

         ST_RUN, ST_TAIL: begin
            if (advance) begin
               left_in      = pk_left;
               pack_reg_in  = pk_stat.word_done ? '0 : pk_word;
               pack_fill_in = pk_stat.word_done ? '0 : pk_fill;
               if (pk_stat.word_done && !drop) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.out_word    = OUT_WORD_W'(pk_word);
                  rsp_in.bit_count   = BIT_COUNT_W'(WordBits);
                  rsp_in.end_of_run  = word_final ||
                                       (res_cnt_ff == ResW'(MAX_RESULTS - 1));
                  rsp_in.range_error = 1'b0;
                  res_cnt_in         = res_cnt_ff + ResW'(1);
               end
               if (pk_stat.seg_done) begin
                  if (state_ff == ST_RUN) begin
                     left_in  = VALUE_W'(tail_len_ff);
                     state_in = ST_TAIL;
                  end else if (last_ff && !pk_stat.word_done) begin
                     state_in = ST_FLUSH;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end

         ST_FLUSH: begin
            if (out_free || drop) begin
               if (!drop) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.out_word    = OUT_WORD_W'(flush_word);
                  rsp_in.bit_count   = BIT_COUNT_W'(pack_fill_ff);
                  rsp_in.end_of_run  = 1'b1;
                  rsp_in.range_error = 1'b0;
                  res_cnt_in         = res_cnt_ff + ResW'(1);
               end
               pack_reg_in  = '0;
               pack_fill_in = '0;
               state_in     = ST_IDLE;
            end
         end

         ST_ERROR: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.end_of_run  = 1'b1;
               rsp_in.range_error = 1'b1;
               // carry the pending bits out when this beat also closes the stream
               if (last_ff && pack_fill_ff != '0) begin
                  rsp_in.out_word  = OUT_WORD_W'(flush_word);
                  rsp_in.bit_count = BIT_COUNT_W'(pack_fill_ff);
                  pack_reg_in      = '0;
                  pack_fill_in     = '0;
               end else begin
                  rsp_in.out_word  = '0;
                  rsp_in.bit_count = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         res_cnt_ff         <= '0;
         pack_reg_ff        <= '0;
         pack_fill_ff       <= '0;
         rsp_valid_ff       <= 1'b0;
         use_codebook_ff    <= 1'b1;
         codebook_number_ff <= '0;
         explicit_k_ff      <= K_W'(1);
         explicit_class_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_cnt_ff   <= res_cnt_in;
         pack_reg_ff  <= pack_reg_in;
         pack_fill_ff <= pack_fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_USE_CODEBOOK:    use_codebook_ff    <= csr_data[0];
               CSR_CODEBOOK_NUMBER: codebook_number_ff <= CB_W'(csr_data);
               CSR_EXPLICIT_K:      explicit_k_ff      <= K_W'(csr_data);
               CSR_EXPLICIT_CLASS:  explicit_class_ff  <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      last_ff     <= last_in;
      k_ff        <= k_in;
      cls_ff      <= cls_in;
      t_ff        <= t_in;
      q_ff        <= q_in;
      left_ff     <= left_in;
      tail_ff     <= tail_in;
      tail_len_ff <= tail_len_in;
      rsp_ff      <= rsp_in;
   end

   `ASSERT_ALWAYS(a_fill_below_word, clock, reset, pack_fill_ff < FillW'(WordBits))
   `ASSERT_IMPLY(a_run_has_ones, clock, reset, state_ff == ST_RUN, left_ff != '0)
   `ASSERT_IMPLY(a_partial_is_final, clock, reset, rsp_valid_ff && !rsp_ff.end_of_run, rsp_ff.bit_count == BIT_COUNT_W'(WordBits))
   `ASSERT_IMPLY(a_error_ends_run, clock, reset, rsp_valid_ff && rsp_ff.range_error, rsp_ff.end_of_run)

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import gtc_pkg::*;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 8;
   // Worst quiet spell: the settle wait plus a long run of random stalls.
   localparam int STUCK_LIMIT   = 2000;
   // An item that completes no word can still be packing; let it finish.
   localparam int SETTLE_CYCLES = 48;
   localparam int IDLE_PERCENT  = 34;
   localparam int PRINT_CAP     = 40;
   localparam int PHASES        = 7;
   localparam int PHASE_ITEMS   = 45;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   gtc_req_type            req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   gtc_rsp_type            rsp_payload;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   gtc_csr_index_type      csr_index   = CSR_USE_CODEBOOK;
   logic [CSR_DATA_W-1:0]  csr_data    = '0;

   // Predictor copy of the packer and the registers.
   logic [OUT_WORD_W-1:0]  model_pack;
   int unsigned            model_fill;
   bit                     model_use_cb;
   logic [CB_W-1:0]        model_cb;
   logic [K_W-1:0]         model_k;
   bit                     model_cls;

   gtc_rsp_type            words_due[$];  // expected output beats, oldest first
   gtc_rsp_type            batch[$];      // beats caused by the current symbol

   bit                     quiet = 1'b0;  // set: no gaps, no stalls
   int                     mismatches    = 0;
   int                     symbols_sent  = 0;
   int                     rejects_sent  = 0;
   int                     words_checked = 0;
   int                     modes_applied = 0;
   int                     stuck_cycles  = 0;

   golomb_two_class_bit_encoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Queue one output beat; beats beyond the per-symbol cap are dropped.
   function automatic void emit_word(logic [OUT_WORD_W-1:0] word, int unsigned count, bit err);
      gtc_rsp_type w;
      if (batch.size() >= MAX_RESULTS)
         return;
      w.out_word    = word;
      w.bit_count   = BIT_COUNT_W'(count);
      w.end_of_run  = 1'b0;
      w.range_error = err;
      batch.push_back(w);
   endfunction

   // Shift one code bit in; a full word leaves at once.
   function automatic void pack_bit(bit b);
      model_pack = {model_pack[OUT_WORD_W-2:0], b};
      model_fill++;
      if (model_fill >= WORD_BITS_DEF) begin
         emit_word(model_pack, WORD_BITS_DEF, 1'b0);
         model_pack = '0;
         model_fill = 0;
      end
   endfunction

   // Left-align whatever is pending and emit it.
   function automatic void flush_pending(bit err);
      if (model_fill > 0) begin
         emit_word(model_pack << (WORD_BITS_DEF - model_fill), model_fill, err);
         model_pack = '0;
         model_fill = 0;
      end
   endfunction

   // Code one symbol and append the beats it causes to words_due.
   function automatic void encode_symbol(gtc_req_type sym);
      int unsigned k;
      int unsigned base;
      int unsigned divisor;
      int unsigned rest;
      bit          cls;
      logic [31:0] suffix;
      batch.delete();
      if (sym.value == 0 || sym.value > VALUE_MAX_DEF) begin
         // Rejected: one beat, carrying the flushed word if there is one.
         rejects_sent++;
         if (sym.last && model_fill > 0)
            flush_pending(1'b1);
         else
            emit_word('0, 0, 1'b1);
      end else begin
         if (model_use_cb) begin
            cls = model_cb[0];
            k   = model_cb[0] ? (model_cb >> 1) : (model_cb >> 1) + 1;
         end else begin
            cls = model_cls;
            k   = model_k;
         end
         if (k > SUFFIX_MAX_DEF)
            k = SUFFIX_MAX_DEF;
         base    = 1 << k;
         divisor = cls ? 3 * base : base;
         rest    = sym.value;
         while (rest > divisor) begin
            rest -= divisor;
            pack_bit(1'b1);
         end
         pack_bit(1'b0);
         if (cls) begin
            if (rest <= base) begin
               pack_bit(1'b0);
            end else if (rest <= 2 * base) begin
               rest -= base;
               pack_bit(1'b1);
               pack_bit(1'b0);
            end else begin
               rest -= 2 * base;
               pack_bit(1'b1);
               pack_bit(1'b1);
            end
         end
         suffix = rest - 1;
         for (int i = int'(k) - 1; i >= 0; i--)
            pack_bit(suffix[i]);
         if (sym.last)
            flush_pending(1'b0);
      end
      if (batch.size() > 0)
         batch[batch.size() - 1].end_of_run = 1'b1;
      foreach (batch[i])
         words_due.push_back(batch[i]);
   endfunction

   // ------------------------------------------------------------------
   // Drivers, checker, watchdog
   // ------------------------------------------------------------------

   function automatic bit take_gap();
      return !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_CAP)
         $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   // Send one beat on req. Call at a rising edge; returns at the edge that
   // took the beat, with valid still up so a back-to-back beat needs no dip.
   task automatic send_symbol(input logic [VALUE_W-1:0] value, input logic last);
      gtc_req_type sym;
      sym.value = value;
      sym.last  = last;
      while (take_gap()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= sym;
      // Sample stall mid-cycle: the edge that follows takes the beat.
      forever begin
         @(negedge clock);
         if (!req_stall)
            break;
         @(posedge clock);
      end
      encode_symbol(sym);
      symbols_sent++;
      @(posedge clock);
   endtask

   // Drop valid, hold until every expected beat has arrived, then let the
   // packer finish any symbol that completed no word.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (words_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input gtc_csr_index_type index, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      forever begin
         @(negedge clock);
         if (csr_ready)
            break;
         @(posedge clock);
      end
      case (index)
         CSR_USE_CODEBOOK:    model_use_cb = data[0];
         CSR_CODEBOOK_NUMBER: model_cb     = data;
         CSR_EXPLICIT_K:      model_k      = data;
         CSR_EXPLICIT_CLASS:  model_cls    = data[0];
         default: ;
      endcase
      @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Rewrite all four registers once the block has gone idle.
   task automatic apply_mode(input bit use_cb, input logic [CB_W-1:0] cb,
                             input logic [K_W-1:0] k, input bit cls);
      wait_until_idle();
      write_csr(CSR_USE_CODEBOOK, CSR_DATA_W'(use_cb));
      write_csr(CSR_CODEBOOK_NUMBER, cb);
      write_csr(CSR_EXPLICIT_K, k);
      write_csr(CSR_EXPLICIT_CLASS, CSR_DATA_W'(cls));
      modes_applied++;
   endtask

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   // Compare each accepted rsp beat against the oldest expectation.
   always @(negedge clock) begin : check_words
      gtc_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (words_due.size() == 0) begin
            report_mismatch($sformatf("unexpected beat word=%h count=%0d",
                                      rsp_payload.out_word, rsp_payload.bit_count));
         end else begin
            want = words_due.pop_front();
            words_checked++;
            if (rsp_payload.out_word !== want.out_word)
               report_mismatch($sformatf("out_word %h, expected %h",
                                         rsp_payload.out_word, want.out_word));
            if (rsp_payload.bit_count !== want.bit_count)
               report_mismatch($sformatf("bit_count %0d, expected %0d",
                                         rsp_payload.bit_count, want.bit_count));
            if (rsp_payload.end_of_run !== want.end_of_run)
               report_mismatch($sformatf("end_of_run %b, expected %b",
                                         rsp_payload.end_of_run, want.end_of_run));
            if (rsp_payload.range_error !== want.range_error)
               report_mismatch($sformatf("range_error %b, expected %b",
                                         rsp_payload.range_error, want.range_error));
         end
      end
   end

   // Abort if no channel moves a beat for too long.
   always @(negedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("timeout: no beat moved in %0d cycles", STUCK_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset defaults: codebook 0, i.e. class 0 with one suffix bit.
   task automatic test_reset_defaults();
      send_symbol(16'd1, 1'b0);
      send_symbol(16'd2, 1'b0);
      send_symbol(16'd3, 1'b0);
      send_symbol(16'd4, 1'b1);
   endtask

   // Zero, the top of the range, just above it and all ones; a reject that
   // carries a flushed word and one that finds nothing pending.
   task automatic test_range_limits();
      send_symbol(16'd0, 1'b0);
      send_symbol(16'hFFFF, 1'b0);
      send_symbol(VALUE_W'(VALUE_MAX_DEF), 1'b0);
      send_symbol(VALUE_W'(VALUE_MAX_DEF + 1), 1'b0);
      send_symbol(16'd5, 1'b0);
      send_symbol(16'd0, 1'b1);
      send_symbol(16'd0, 1'b1);
   endtask

   task automatic test_explicit_extremes();
      // No suffix, divisor 1: the longest unary run the range allows.
      apply_mode(1'b0, '0, 5'd0, 1'b0);
      send_symbol(VALUE_W'(VALUE_MAX_DEF), 1'b1);
      // Exactly one full word, so the flush has nothing left to emit.
      send_symbol(16'd64, 1'b1);
      // Class 1, k=2: every middle code, on both sides of each boundary.
      apply_mode(1'b0, '0, 5'd2, 1'b1);
      send_symbol(16'd3, 1'b0);
      send_symbol(16'd4, 1'b0);
      send_symbol(16'd5, 1'b0);
      send_symbol(16'd8, 1'b0);
      send_symbol(16'd9, 1'b0);
      send_symbol(16'd12, 1'b0);
      send_symbol(16'd25, 1'b1);
      // Suffix size above the limit saturates.
      apply_mode(1'b0, '0, 5'd31, 1'b0);
      send_symbol(16'd1, 1'b1);
      // Class 1 with no suffix bits.
      apply_mode(1'b0, '0, 5'd0, 1'b1);
      send_symbol(VALUE_W'(VALUE_MAX_DEF), 1'b1);
   endtask

   // Stop sending mid-word until every beat is back, then carry on.
   task automatic test_hold_until_drained();
      apply_mode(1'b1, 5'd3, 5'd1, 1'b0);
      for (int i = 0; i < 6; i++)
         send_symbol(VALUE_W'($urandom_range(1, 40)), 1'b0);
      wait_until_idle();
      for (int i = 0; i < 6; i++)
         send_symbol(VALUE_W'($urandom_range(1, 40)), 1'b0);
      send_symbol(16'd7, 1'b1);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) return VALUE_W'($urandom_range(1, 64));
      if (r < 78) return VALUE_W'($urandom_range(1, VALUE_MAX_DEF));
      if (r < 85) return $urandom_range(0, 1) ? VALUE_W'(VALUE_MAX_DEF) : VALUE_W'(1);
      if (r < 92) return '0;
      return VALUE_W'($urandom_range(VALUE_MAX_DEF + 1, 16'hFFFF));
   endfunction

   // Random streams under a series of settings, extremes first.
   task automatic test_random_stream();
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: apply_mode(1'b1, 5'd31, 5'($urandom_range(0, 31)), 1'($urandom));
            1: apply_mode(1'b1, 5'd30, 5'($urandom_range(0, 31)), 1'($urandom));
            2: apply_mode(1'b0, 5'($urandom_range(0, 31)), 5'd0, 1'($urandom));
            3: apply_mode(1'b0, 5'($urandom_range(0, 31)), 5'd16, 1'b1);
            4: apply_mode(1'b0, 5'($urandom_range(0, 31)), 5'd31, 1'($urandom));
            default: apply_mode(1'($urandom), 5'($urandom_range(0, 31)),
                                5'($urandom_range(0, 31)), 1'($urandom));
         endcase
         // One whole phase runs flat out on both sides.
         quiet = (p == 3);
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_symbol(pick_value(), $urandom_range(0, 5) == 0);
         quiet = 1'b0;
      end
      send_symbol(16'd1, 1'b1);
   endtask

   initial begin
      model_pack   = '0;
      model_fill   = 0;
      model_use_cb = 1'b1;
      model_cb     = '0;
      model_k      = 5'd1;
      model_cls    = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_range_limits();
      test_explicit_extremes();
      test_hold_until_drained();
      test_random_stream();
      wait_until_idle();

      $display("Sent %0d symbols (%0d rejected) across %0d register settings,",
               symbols_sent, rejects_sent, modes_applied);
      $display("checked %0d output words, %0d mismatches.", words_checked, mismatches);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
